// ===== src/pbmc_pkg.sv =====
package pbmc_pkg;

    // Default counter width of the three tick timers
    localparam int TIMER_WIDTH = 16;

    // Width of each configuration register
    localparam int CFG_WIDTH = 16;

    // Register indexes on the configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD         = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDLE_LOAD    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH-1:0] PRESS_WINDOW_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] HOLD_RESET         = 16'd300;
    localparam logic [CFG_WIDTH-1:0] IDLE_LOAD_RESET    = 16'd3000;

    // Main machine states
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_READY  = 2'd1;
    localparam logic [1:0] MODE_ACTIVE = 2'd2;
    localparam logic [1:0] MODE_CHARGE = 2'd3;

    // Indicator codes
    localparam logic [1:0] IND_OFF   = 2'd0;
    localparam logic [1:0] IND_ON    = 2'd1;
    localparam logic [1:0] IND_BLINK = 2'd2;

    // Sampled input levels, button in bit 0
    typedef struct packed {
        logic source_level;
        logic load_level;
        logic button_level;
    } levels_t;

    // One result, indicator in the lowest bits
    typedef struct packed {
        logic       torch_enable;
        logic       charge_out_enable;
        logic       charge_in_enable;
        logic [1:0] indicator_mode;
    } result_t;

    localparam int IN_DATA_WIDTH  = 8;
    localparam int OUT_DATA_WIDTH = 8;

    // Output levels for a main state and torch state
    function automatic result_t mode_result(input logic [1:0] mode, input logic torch);
        result_t r;
        r.indicator_mode    = IND_OFF;
        r.charge_in_enable  = 1'b0;
        r.charge_out_enable = 1'b0;
        r.torch_enable      = torch;
        unique case (mode)
            MODE_READY:
            begin
                r.indicator_mode = IND_ON;
            end
            MODE_ACTIVE:
            begin
                r.indicator_mode    = IND_ON;
                r.charge_out_enable = 1'b1;
            end
            MODE_CHARGE:
            begin
                r.indicator_mode   = IND_BLINK;
                r.charge_in_enable = 1'b1;
            end
            default:
            begin
                r.indicator_mode = IND_OFF;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/pbmc_step.sv =====
// One tick of the main and torch machines: next state and result
module pbmc_step #(
    parameter int TIMER_WIDTH = pbmc_pkg::TIMER_WIDTH
) (
    input  pbmc_pkg::levels_t                levels,
    input  pbmc_pkg::levels_t                prev_levels,
    input  logic [1:0]                       mode,
    input  logic                             torch,
    input  logic [TIMER_WIDTH-1:0]           press_cnt,
    input  logic                             press_armed,
    input  logic [TIMER_WIDTH-1:0]           hold_cnt,
    input  logic                             hold_armed,
    input  logic [TIMER_WIDTH-1:0]           idle_cnt,
    input  logic                             idle_armed,
    input  logic [pbmc_pkg::CFG_WIDTH-1:0]   press_window_ticks,
    input  logic [pbmc_pkg::CFG_WIDTH-1:0]   hold_ticks,
    input  logic [pbmc_pkg::CFG_WIDTH-1:0]   idle_load_ticks,
    output logic [1:0]                       mode_next,
    output logic                             torch_next,
    output logic [TIMER_WIDTH-1:0]           press_cnt_next,
    output logic                             press_armed_next,
    output logic [TIMER_WIDTH-1:0]           hold_cnt_next,
    output logic                             hold_armed_next,
    output logic [TIMER_WIDTH-1:0]           idle_cnt_next,
    output logic                             idle_armed_next,
    output pbmc_pkg::result_t                result
);

    localparam int EXT_WIDTH = TIMER_WIDTH + pbmc_pkg::CFG_WIDTH;

    logic btn_rise, btn_fall, load_rise, load_fall, src_rise, src_fall;
    logic [TIMER_WIDTH-1:0] press_dec, hold_dec, idle_dec;
    logic press_exp, hold_exp, idle_exp, press_running;
    logic [EXT_WIDTH-1:0] press_ext, hold_ext, idle_ext;
    logic [TIMER_WIDTH-1:0] press_load, hold_load, idle_load;
    logic [TIMER_WIDTH-1:0] p_cnt, h_cnt, i_cnt;
    logic p_arm, h_arm, i_arm;

    // Edges against the previous tick
    assign btn_rise  =  levels.button_level & ~prev_levels.button_level;
    assign btn_fall  = ~levels.button_level &  prev_levels.button_level;
    assign load_rise =  levels.load_level   & ~prev_levels.load_level;
    assign load_fall = ~levels.load_level   &  prev_levels.load_level;
    assign src_rise  =  levels.source_level & ~prev_levels.source_level;
    assign src_fall  = ~levels.source_level &  prev_levels.source_level;

    // Load values, truncated or zero-extended to the timer width
    assign press_ext  = {{TIMER_WIDTH{1'b0}}, press_window_ticks};
    assign hold_ext   = {{TIMER_WIDTH{1'b0}}, hold_ticks};
    assign idle_ext   = {{TIMER_WIDTH{1'b0}}, idle_load_ticks};
    assign press_load = press_ext[TIMER_WIDTH-1:0];
    assign hold_load  = hold_ext[TIMER_WIDTH-1:0];
    assign idle_load  = idle_ext[TIMER_WIDTH-1:0];

    // Count down armed timers that are not yet at zero
    assign press_dec = (press_armed && press_cnt != '0) ? press_cnt - TIMER_WIDTH'(1) : press_cnt;
    assign hold_dec  = (hold_armed && hold_cnt != '0) ? hold_cnt - TIMER_WIDTH'(1) : hold_cnt;
    assign idle_dec  = (idle_armed && idle_cnt != '0) ? idle_cnt - TIMER_WIDTH'(1) : idle_cnt;

    assign press_exp     = press_armed && press_dec == '0;
    assign hold_exp      = hold_armed && hold_dec == '0;
    assign idle_exp      = idle_armed && idle_dec == '0;
    assign press_running = press_armed && press_dec != '0;

    // Main machine, hold and idle timers, torch and press window
    always_comb
    begin
        mode_next  = mode;
        torch_next = torch;
        p_cnt = press_dec;
        p_arm = press_armed;
        h_cnt = hold_dec;
        h_arm = hold_armed;
        i_cnt = idle_dec;
        i_arm = idle_armed;

        unique case (mode)
            pbmc_pkg::MODE_OFF:
            begin
                if (press_exp)
                begin
                    i_cnt     = idle_load;
                    i_arm     = 1'b1;
                    mode_next = pbmc_pkg::MODE_READY;
                end
                else if (src_rise)
                    mode_next = pbmc_pkg::MODE_CHARGE;
                else if (load_rise)
                    mode_next = pbmc_pkg::MODE_ACTIVE;
            end
            pbmc_pkg::MODE_READY:
            begin
                if (hold_exp || idle_exp)
                    mode_next = pbmc_pkg::MODE_OFF;
                else if (src_rise)
                    mode_next = pbmc_pkg::MODE_CHARGE;
                else if (load_rise)
                    mode_next = pbmc_pkg::MODE_ACTIVE;
                if (btn_rise)
                begin
                    h_cnt = hold_load;
                    h_arm = 1'b1;
                end
                if (btn_fall)
                    h_arm = 1'b0;
            end
            pbmc_pkg::MODE_ACTIVE:
            begin
                if (hold_exp)
                    mode_next = pbmc_pkg::MODE_OFF;
                else if (src_rise)
                    mode_next = pbmc_pkg::MODE_CHARGE;
                else if (load_fall)
                begin
                    i_cnt     = idle_load;
                    i_arm     = 1'b1;
                    mode_next = pbmc_pkg::MODE_READY;
                end
                if (btn_rise)
                begin
                    h_cnt = hold_load;
                    h_arm = 1'b1;
                end
                if (btn_fall)
                    h_arm = 1'b0;
            end
            default:
            begin
                if (src_fall)
                    mode_next = pbmc_pkg::MODE_OFF;
            end
        endcase

        // Second press inside the window toggles the torch
        if (btn_rise)
        begin
            if (press_running)
            begin
                p_arm      = 1'b0;
                torch_next = ~torch;
            end
            else
            begin
                p_cnt = press_load;
                p_arm = 1'b1;
            end
        end
    end

    // Any armed timer left at zero is dropped
    assign press_cnt_next   = p_cnt;
    assign hold_cnt_next    = h_cnt;
    assign idle_cnt_next    = i_cnt;
    assign press_armed_next = p_arm && p_cnt != '0;
    assign hold_armed_next  = h_arm && h_cnt != '0;
    assign idle_armed_next  = i_arm && i_cnt != '0;

    assign result = pbmc_pkg::mode_result(mode_next, torch_next);

endmodule

// ===== src/power_bank_mode_controller_core.sv =====
// Power bank mode controller.
// Input stream (s_*): one request per tick carrying the button, load and
// source levels. Output stream (m_*): one result per request with the
// indicator mode and the charge-in, charge-out and torch enables of the
// state after that tick.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 press window, 1 hold time, 2 idle load time); write only while idle.
// Path: a request taken is held in the input register; its result is loaded
// into the output register once that is free or being read, and shows on m_*.
// Throughput: one request per cycle while the receiver takes results; the tick
// update is a single combinational pass between the input register and the
// state and output registers.
// When the receiver stalls, the result holds in the output register and an
// empty input register still takes one more request; s_tready then drops until
// m_tready returns.
// Reset: both machines off, timers disarmed, previous levels zero and the
// configuration registers at 50, 300 and 3000 ticks.
module power_bank_mode_controller_core #(
    parameter int TIMER_WIDTH = pbmc_pkg::TIMER_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // bit 0 button_level, bit 1 load_level, bit 2 source_level
    input  logic [pbmc_pkg::IN_DATA_WIDTH-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // bits 1:0 indicator_mode, 2 charge_in_enable, 3 charge_out_enable, 4 torch_enable
    output logic [pbmc_pkg::OUT_DATA_WIDTH-1:0]    m_tdata,
    input  logic                                   cfg_we,
    input  logic [pbmc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [pbmc_pkg::CFG_WIDTH-1:0]         cfg_data
);

    logic in_valid_reg;
    pbmc_pkg::levels_t in_levels_reg;
    logic out_valid_reg;
    pbmc_pkg::result_t out_data_reg;

    logic [pbmc_pkg::CFG_WIDTH-1:0] press_window_reg, hold_ticks_reg, idle_load_reg;

    logic [1:0] mode_reg, mode_next;
    logic torch_reg, torch_next;
    logic [TIMER_WIDTH-1:0] press_cnt_reg, press_cnt_next;
    logic [TIMER_WIDTH-1:0] hold_cnt_reg, hold_cnt_next;
    logic [TIMER_WIDTH-1:0] idle_cnt_reg, idle_cnt_next;
    logic press_armed_reg, press_armed_next;
    logic hold_armed_reg, hold_armed_next;
    logic idle_armed_reg, idle_armed_next;
    pbmc_pkg::levels_t prev_levels_reg;
    pbmc_pkg::result_t result;

    logic advance;

    // Pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_window_reg <= pbmc_pkg::PRESS_WINDOW_RESET;
            hold_ticks_reg   <= pbmc_pkg::HOLD_RESET;
            idle_load_reg    <= pbmc_pkg::IDLE_LOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbmc_pkg::CFG_PRESS_WINDOW: press_window_reg <= cfg_data;
                pbmc_pkg::CFG_HOLD:         hold_ticks_reg   <= cfg_data;
                pbmc_pkg::CFG_IDLE_LOAD:    idle_load_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_levels_reg <= s_tdata[2:0];
    end

    // Tick update
    pbmc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .levels             (in_levels_reg),
        .prev_levels        (prev_levels_reg),
        .mode               (mode_reg),
        .torch              (torch_reg),
        .press_cnt          (press_cnt_reg),
        .press_armed        (press_armed_reg),
        .hold_cnt           (hold_cnt_reg),
        .hold_armed         (hold_armed_reg),
        .idle_cnt           (idle_cnt_reg),
        .idle_armed         (idle_armed_reg),
        .press_window_ticks (press_window_reg),
        .hold_ticks         (hold_ticks_reg),
        .idle_load_ticks    (idle_load_reg),
        .mode_next          (mode_next),
        .torch_next         (torch_next),
        .press_cnt_next     (press_cnt_next),
        .press_armed_next   (press_armed_next),
        .hold_cnt_next      (hold_cnt_next),
        .hold_armed_next    (hold_armed_next),
        .idle_cnt_next      (idle_cnt_next),
        .idle_armed_next    (idle_armed_next),
        .result             (result)
    );

    // Machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= pbmc_pkg::MODE_OFF;
            torch_reg       <= 1'b0;
            press_cnt_reg   <= '0;
            press_armed_reg <= 1'b0;
            hold_cnt_reg    <= '0;
            hold_armed_reg  <= 1'b0;
            idle_cnt_reg    <= '0;
            idle_armed_reg  <= 1'b0;
            prev_levels_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            torch_reg       <= torch_next;
            press_cnt_reg   <= press_cnt_next;
            press_armed_reg <= press_armed_next;
            hold_cnt_reg    <= hold_cnt_next;
            hold_armed_reg  <= hold_armed_next;
            idle_cnt_reg    <= idle_cnt_next;
            idle_armed_reg  <= idle_armed_next;
            prev_levels_reg <= in_levels_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule

// ===== tb/power_bank_mode_controller_core_tb.sv =====
// Timers of the predictor, used as array indexes
typedef enum int {
    TMR_PRESS = 0,
    TMR_HOLD  = 1,
    TMR_IDLE  = 2
} tick_timer_e;

// Receiver stall patterns
typedef enum int {
    RX_OPEN     = 0,
    RX_RANDOM   = 1,
    RX_PERIODIC = 2,
    RX_SPARSE   = 3
} rx_style_e;

// Tracks both machines tick by tick and checks every result against its prediction
class mode_checker;
    logic [pbmc_pkg::CFG_WIDTH-1:0]   press_window;
    logic [pbmc_pkg::CFG_WIDTH-1:0]   hold_len;
    logic [pbmc_pkg::CFG_WIDTH-1:0]   idle_len;
    logic [1:0]                       main_mode;
    bit                               torch;
    logic [pbmc_pkg::TIMER_WIDTH-1:0] tmr_count [3];
    bit                               tmr_armed [3];
    pbmc_pkg::levels_t                last_levels;
    pbmc_pkg::result_t                expected_q [$];
    int                               mismatches;
    int                               checked;
    int                               ticks;
    int                               toggles;
    int                               mode_seen [4];

    function new();
        press_window = pbmc_pkg::PRESS_WINDOW_RESET;
        hold_len     = pbmc_pkg::HOLD_RESET;
        idle_len     = pbmc_pkg::IDLE_LOAD_RESET;
        main_mode    = pbmc_pkg::MODE_OFF;
        torch        = 1'b0;
        last_levels  = '0;
        foreach (tmr_count[i])
        begin
            tmr_count[i] = '0;
            tmr_armed[i] = 1'b0;
        end
        foreach (mode_seen[i])
            mode_seen[i] = 0;
        mismatches = 0;
        checked    = 0;
        ticks      = 0;
        toggles    = 0;
    endfunction

    function void set_regs(logic [15:0] p, logic [15:0] h, logic [15:0] i);
        press_window = p;
        hold_len     = h;
        idle_len     = i;
    endfunction

    function void arm(tick_timer_e t, logic [pbmc_pkg::CFG_WIDTH-1:0] ticks_in);
        tmr_count[t] = ticks_in;
        tmr_armed[t] = 1'b1;
    endfunction

    function bit running(tick_timer_e t);
        return tmr_armed[t] && tmr_count[t] != '0;
    endfunction

    function void tick_down(tick_timer_e t);
        if (running(t))
            tmr_count[t] = tmr_count[t] - 1'b1;
    endfunction

    // Expiry test; a caught expiry disarms the timer
    function bit fired(tick_timer_e t);
        if (tmr_armed[t] && tmr_count[t] == '0)
        begin
            tmr_armed[t] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // One accepted request: advance the machines and queue the outputs of the new state
    function void note_levels(pbmc_pkg::levels_t lv);
        bit btn_rise, btn_fall, load_rise, load_fall, src_rise, src_fall;
        pbmc_pkg::result_t r;
        btn_rise  = lv.button_level && !last_levels.button_level;
        btn_fall  = !lv.button_level && last_levels.button_level;
        load_rise = lv.load_level && !last_levels.load_level;
        load_fall = !lv.load_level && last_levels.load_level;
        src_rise  = lv.source_level && !last_levels.source_level;
        src_fall  = !lv.source_level && last_levels.source_level;

        tick_down(TMR_PRESS);
        tick_down(TMR_HOLD);
        tick_down(TMR_IDLE);

        // main machine
        case (main_mode)
            pbmc_pkg::MODE_OFF:
            begin
                if (fired(TMR_PRESS))
                begin
                    arm(TMR_IDLE, idle_len);
                    main_mode = pbmc_pkg::MODE_READY;
                end
                else if (src_rise)
                    main_mode = pbmc_pkg::MODE_CHARGE;
                else if (load_rise)
                    main_mode = pbmc_pkg::MODE_ACTIVE;
            end
            pbmc_pkg::MODE_READY:
            begin
                if (fired(TMR_HOLD))
                    main_mode = pbmc_pkg::MODE_OFF;
                else if (fired(TMR_IDLE))
                    main_mode = pbmc_pkg::MODE_OFF;
                else if (src_rise)
                    main_mode = pbmc_pkg::MODE_CHARGE;
                else if (load_rise)
                    main_mode = pbmc_pkg::MODE_ACTIVE;
                if (btn_rise)
                    arm(TMR_HOLD, hold_len);
                if (btn_fall)
                    tmr_armed[TMR_HOLD] = 1'b0;
            end
            pbmc_pkg::MODE_ACTIVE:
            begin
                if (fired(TMR_HOLD))
                    main_mode = pbmc_pkg::MODE_OFF;
                else if (src_rise)
                    main_mode = pbmc_pkg::MODE_CHARGE;
                else if (load_fall)
                begin
                    arm(TMR_IDLE, idle_len);
                    main_mode = pbmc_pkg::MODE_READY;
                end
                if (btn_rise)
                    arm(TMR_HOLD, hold_len);
                if (btn_fall)
                    tmr_armed[TMR_HOLD] = 1'b0;
            end
            default:
            begin
                if (src_fall)
                    main_mode = pbmc_pkg::MODE_OFF;
            end
        endcase

        // torch machine: second press inside the window toggles
        if (running(TMR_PRESS))
        begin
            if (btn_rise)
            begin
                tmr_armed[TMR_PRESS] = 1'b0;
                torch = ~torch;
                toggles++;
            end
        end
        else if (btn_rise)
            arm(TMR_PRESS, press_window);

        r.indicator_mode    = pbmc_pkg::IND_OFF;
        r.charge_in_enable  = 1'b0;
        r.charge_out_enable = 1'b0;
        r.torch_enable      = torch;
        case (main_mode)
            pbmc_pkg::MODE_READY:
                r.indicator_mode = pbmc_pkg::IND_ON;
            pbmc_pkg::MODE_ACTIVE:
            begin
                r.indicator_mode    = pbmc_pkg::IND_ON;
                r.charge_out_enable = 1'b1;
            end
            pbmc_pkg::MODE_CHARGE:
            begin
                r.indicator_mode   = pbmc_pkg::IND_BLINK;
                r.charge_in_enable = 1'b1;
            end
            default:
                r.indicator_mode = pbmc_pkg::IND_OFF;
        endcase

        // uncaught expiries are dropped
        void'(fired(TMR_PRESS));
        void'(fired(TMR_HOLD));
        void'(fired(TMR_IDLE));

        last_levels = lv;
        mode_seen[main_mode]++;
        ticks++;
        expected_q.push_back(r);
    endfunction

    function void report(time stamp, string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s mismatch, expected %0d, got %0d", stamp, what, exp_v, act_v);
        else if (mismatches == 101)
            $display("%0t: further mismatches not shown", stamp);
    endfunction

    // One accepted result against the oldest prediction
    function void check_outputs(pbmc_pkg::result_t got, time stamp);
        pbmc_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            report(stamp, "unexpected result", 0, int'(got));
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got.indicator_mode !== want.indicator_mode)
            report(stamp, "indicator_mode", want.indicator_mode, got.indicator_mode);
        if (got.charge_in_enable !== want.charge_in_enable)
            report(stamp, "charge_in_enable", want.charge_in_enable, got.charge_in_enable);
        if (got.charge_out_enable !== want.charge_out_enable)
            report(stamp, "charge_out_enable", want.charge_out_enable,
                   got.charge_out_enable);
        if (got.torch_enable !== want.torch_enable)
            report(stamp, "torch_enable", want.torch_enable, got.torch_enable);
    endfunction
endclass

module power_bank_mode_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbmc_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_ITEMS  = 40;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_DATA_WIDTH-1:0]   s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_DATA_WIDTH-1:0]  m_tdata;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    mode_checker sb;

    // stimulus state
    levels_t        cur_lv;
    int             btn_left;
    int             load_left;
    int             src_left;
    int             burst_left;
    int             gapless_left;
    logic [15:0]    cur_pw;
    logic [15:0]    cur_h;
    bit             hold_off_req;
    int             long_stalls;
    int             settings_used;

    logic [2:0] dir_reset_vals [9] = '{3'b000, 3'b100, 3'b000, 3'b010, 3'b011,
                                       3'b010, 3'b011, 3'b111, 3'b000};
    logic [2:0] dir_short_vals [15] = '{3'b001, 3'b000, 3'b000, 3'b001, 3'b001,
                                        3'b001, 3'b001, 3'b000, 3'b001, 3'b000,
                                        3'b000, 3'b000, 3'b000, 3'b000, 3'b000};

    power_bank_mode_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Accepted requests and results go to the checker; result first, it is the older
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_outputs(result_t'(m_tdata[4:0]), $time);
            if (s_tvalid && s_tready)
                sb.note_levels(levels_t'(s_tdata[2:0]));
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles at %0t", STALL_LIMIT, $time);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin
        rx_style_e style;
        int        span;
        int        beat;
        m_tready <= 1'b0;
        style = RX_OPEN;
        span  = 0;
        beat  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
                long_stalls++;
            end
            else
            begin
                if (span == 0)
                begin
                    style = rx_style_e'($urandom_range(0, 3));
                    span  = $urandom_range(16, 96);
                end
                span--;
                beat++;
                case (style)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: m_tready <= ((beat % 5) < 3);
                    default:     m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run length of the button level, scaled to the current window and hold time
    function automatic int button_run();
        int cap_pw;
        int cap_h;
        int lo;
        cap_pw = (cur_pw > 40) ? 40 : int'(cur_pw);
        cap_h  = (cur_h > 400) ? 400 : int'(cur_h);
        lo     = (cap_h > 2) ? cap_h - 2 : 1;
        case ($urandom_range(0, 5))
            0, 1:    return $urandom_range(1, 3);
            2:       return $urandom_range(1, cap_pw + 2);
            3:       return $urandom_range(lo, cap_h + 3);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic int supply_run();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    // Next tick: slowly varying levels, with the odd fully random tick as noise
    function automatic levels_t next_levels();
        levels_t noise;
        if (btn_left <= 0)
        begin
            cur_lv.button_level = ~cur_lv.button_level;
            btn_left = button_run();
        end
        if (load_left <= 0)
        begin
            cur_lv.load_level = ~cur_lv.load_level;
            load_left = supply_run();
        end
        if (src_left <= 0)
        begin
            cur_lv.source_level = ~cur_lv.source_level;
            src_left = supply_run();
        end
        btn_left--;
        load_left--;
        src_left--;
        if ($urandom_range(0, 19) == 0)
        begin
            noise = levels_t'(3'($urandom_range(0, 7)));
            return noise;
        end
        return cur_lv;
    endfunction

    // Offer one request; the sender runs in bursts with random gaps between
    task automatic push_levels(levels_t lv);
        logic [IN_DATA_WIDTH-1:0] word;
        int gap;
        word      = '0;
        word[2:0] = lv;
        if (gapless_left > 0)
            gapless_left--;
        else if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_config(logic [15:0] p, logic [15:0] h, logic [15:0] i);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRESS_WINDOW;
        cfg_data  <= p;
        @(posedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_IDLE_LOAD;
        cfg_data  <= i;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_regs(p, h, i);
        cur_pw = p;
        cur_h  = h;
        settings_used++;
    endtask

    task automatic run_phase(logic [15:0] p, logic [15:0] h, logic [15:0] i, int n,
                             bit with_hold_off);
        drain();
        write_config(p, h, i);
        for (int k = 0; k < n; k++)
        begin
            // long receiver hold-off while the sender keeps offering
            if (with_hold_off && k == n / 2)
            begin
                hold_off_req = 1'b1;
                gapless_left = HOLD_OFF_ITEMS;
            end
            push_levels(next_levels());
        end
    endtask

    initial
    begin
        sb = new();
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_PRESS_WINDOW;
        cfg_data     <= '0;
        cur_lv        = '0;
        btn_left      = 0;
        load_left     = 0;
        src_left      = 0;
        burst_left    = 0;
        gapless_left  = 0;
        cur_pw        = PRESS_WINDOW_RESET;
        cur_h         = HOLD_RESET;
        hold_off_req  = 1'b0;
        long_stalls   = 0;
        settings_used = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: charge in and out, active, torch double press
        foreach (dir_reset_vals[k])
            push_levels(levels_t'(dir_reset_vals[k]));
        drain();

        // directed, short timers: single press to ready, hold timeout, idle timeout
        write_config(16'd2, 16'd3, 16'd4);
        foreach (dir_short_vals[k])
            push_levels(levels_t'(dir_short_vals[k]));

        // random phases over several settings, extremes included
        run_phase(16'd1, 16'd1, 16'd1, 200, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 150, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 150, 1'b0);
        run_phase(PRESS_WINDOW_RESET, HOLD_RESET, IDLE_LOAD_RESET, 250, 1'b1);
        run_phase(16'd0, 16'd5, 16'hFFFF, 100, 1'b0);
        run_phase(16'd3, 16'd0, 16'd10, 100, 1'b0);
        for (int ph = 0; ph < 6; ph++)
            run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(2, 20)),
                      16'($urandom_range(3, 40)), 150, ph == 2);

        drain();
        repeat (5) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        $display("ran %0d ticks over %0d register settings, %0d results checked, %0d long stalls",
                 sb.ticks, settings_used, sb.checked, long_stalls);
        $display("ticks ending in off/ready/active/charge: %0d/%0d/%0d/%0d, torch toggles %0d",
                 sb.mode_seen[MODE_OFF], sb.mode_seen[MODE_READY],
                 sb.mode_seen[MODE_ACTIVE], sb.mode_seen[MODE_CHARGE], sb.toggles);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
